// ===== design/word_frame_deframer_with_sum_assert.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects clk and rst_n in scope.
`ifndef WORD_FRAME_DEFRAMER_WITH_SUM_ASSERT_SVH
`define WORD_FRAME_DEFRAMER_WITH_SUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WFD_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WFD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== design/wfd_pkg.sv =====
`default_nettype none

package wfd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_WAIT_HEADER = 3'd0,
        PH_LENGTH      = 3'd1,
        PH_PAYLOAD     = 3'd2,
        PH_CHECKSUM    = 3'd3,
        PH_DONE        = 3'd4,
        PH_LEN_ERROR   = 3'd5
    } phase_t;

    // Final status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN_ERR  = 2'd1;
    localparam logic [1:0] ST_SUM_ERR  = 2'd2;
    localparam logic [1:0] ST_NO_FRAME = 2'd3;

    // Request kinds
    localparam logic CMD_WORD = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEADER_WORD = 1'b0;
    localparam logic CFG_MAX_LENGTH  = 1'b1;

    // Reset values
    localparam logic [15:0] HEADER_WORD_RESET  = 16'h8888;
    localparam logic [15:0] MAX_LENGTH_RESET   = 16'd300;
    localparam logic [15:0] RECEIVED_SUM_RESET = 16'hffff;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] word;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] payload;
        logic [15:0] position;
        logic [1:0]  status;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== design/word_frame_deframer_with_sum.sv =====
// Length-prefixed frame parser with a 16-bit additive checksum. Each request carries either a
// received word (cmd 0) or an end-of-transfer event (cmd 1). Words are ignored until one matches
// header_word; the next word is the payload length (1 to max_length, otherwise the frame is a
// length error). Payload words come out one per request as kind 0 results with their index in
// position, and are summed modulo 2^16; the word after the payload is taken as the checksum and
// any later words are ignored. An end request always yields one kind 1 result with last set and
// status 0 ok, 1 length error, 2 checksum mismatch or 3 incomplete/no frame, and returns the
// parser to hunting for a header; the configuration registers are kept. Rate: one request per
// clock while in_stall is low, since each word needs only one compare, one add and a counter
// update in the parser stage. Each result is registered in the output register, or in the skid
// register when that one is full and stalled; the skid register is one entry deep, so in_stall is
// high only while both hold results. Write header_word (index 0) and max_length (index 1) on
// the configuration channel only while no frame traffic is in flight; cfg_ready is always high.
// The consumer must discard delivered payload words when the final status is not ok.

`default_nettype none

module word_frame_deframer_with_sum (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] word,

    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [15:0]      payload,
    output logic [15:0]      position,
    output logic [1:0]       status,
    output logic             last,

    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    wfd_pkg::cfg_t    cfg_reg, cfg_next;
    wfd_pkg::item_t   item;
    wfd_pkg::result_t res;
    wfd_pkg::result_t out_data;
    logic             res_valid;
    logic             stage_full;
    logic             in_accept;

    // Configuration registers: always ready, hold between writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                wfd_pkg::CFG_HEADER_WORD: cfg_next.header_word = cfg_data;
                wfd_pkg::CFG_MAX_LENGTH:  cfg_next.max_length  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word <= wfd_pkg::HEADER_WORD_RESET;
            cfg_reg.max_length  <= wfd_pkg::MAX_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a request whenever the skid register is free
    assign in_stall  = stage_full;
    assign in_accept = in_valid && !stage_full;

    assign item.cmd  = cmd;
    assign item.word = word;

    wfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (in_accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (stage_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind     = out_data.kind;
    assign payload  = out_data.payload;
    assign position = out_data.position;
    assign status   = out_data.status;
    assign last     = out_data.last;

endmodule

`default_nettype wire

// ===== design/wfd_parser.sv =====
`default_nettype none

`include "word_frame_deframer_with_sum_assert.svh"

module wfd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wfd_pkg::cfg_t   cfg,
    input  wire logic            accept,
    input  wire wfd_pkg::item_t  item,
    output logic                 res_valid,
    output wfd_pkg::result_t     res
);

    wfd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] words_seen_reg, words_seen_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [15:0] received_sum_reg, received_sum_next;
    logic [15:0] words_seen_inc;
    logic [1:0]  end_status;

    assign words_seen_inc = words_seen_reg + 16'd1;

    always_comb
    begin
        unique case (phase_reg)
            wfd_pkg::PH_LEN_ERROR: end_status = wfd_pkg::ST_LEN_ERR;
            wfd_pkg::PH_DONE:
                end_status = (running_sum_reg == received_sum_reg) ? wfd_pkg::ST_OK
                                                                   : wfd_pkg::ST_SUM_ERR;
            default: end_status = wfd_pkg::ST_NO_FRAME;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        words_seen_next   = words_seen_reg;
        running_sum_next  = running_sum_reg;
        received_sum_next = received_sum_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (accept)
        begin
            if (item.cmd == wfd_pkg::CMD_END)
            begin
                // Report and drop the frame
                res_valid         = 1'b1;
                res.kind          = wfd_pkg::KIND_STATUS;
                res.status        = end_status;
                res.last          = 1'b1;
                phase_next        = wfd_pkg::PH_WAIT_HEADER;
                frame_length_next = '0;
                words_seen_next   = '0;
                running_sum_next  = '0;
                received_sum_next = wfd_pkg::RECEIVED_SUM_RESET;
            end
            else
            begin
                unique case (phase_reg)
                    wfd_pkg::PH_WAIT_HEADER:
                    begin
                        if (item.word == cfg.header_word)
                            phase_next = wfd_pkg::PH_LENGTH;
                    end
                    wfd_pkg::PH_LENGTH:
                    begin
                        frame_length_next = item.word;
                        words_seen_next   = '0;
                        if (item.word == 16'd0 || item.word > cfg.max_length)
                            phase_next = wfd_pkg::PH_LEN_ERROR;
                        else
                            phase_next = wfd_pkg::PH_PAYLOAD;
                    end
                    wfd_pkg::PH_PAYLOAD:
                    begin
                        res_valid        = 1'b1;
                        res.kind         = wfd_pkg::KIND_PAYLOAD;
                        res.payload      = item.word;
                        res.position     = words_seen_reg;
                        running_sum_next = running_sum_reg + item.word;
                        words_seen_next  = words_seen_inc;
                        if (words_seen_inc >= frame_length_reg)
                            phase_next = wfd_pkg::PH_CHECKSUM;
                    end
                    wfd_pkg::PH_CHECKSUM:
                    begin
                        received_sum_next = item.word;
                        phase_next        = wfd_pkg::PH_DONE;
                    end
                    default:
                    begin
                        // ignore words after the checksum or after a bad length
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wfd_pkg::PH_WAIT_HEADER;
            frame_length_reg <= '0;
            words_seen_reg   <= '0;
            running_sum_reg  <= '0;
            received_sum_reg <= wfd_pkg::RECEIVED_SUM_RESET;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            words_seen_reg   <= words_seen_next;
            running_sum_reg  <= running_sum_next;
            received_sum_reg <= received_sum_next;
        end
    end

    `WFD_ASSERT_NEXT(a_end_clears, accept && item.cmd == wfd_pkg::CMD_END,
        phase_reg == wfd_pkg::PH_WAIT_HEADER && running_sum_reg == 16'd0,
        "end request did not clear the frame")
    `WFD_ASSERT_NOW(a_payload_count, phase_reg == wfd_pkg::PH_PAYLOAD,
        frame_length_reg != 16'd0 && words_seen_reg < frame_length_reg,
        "payload count out of range")
    `WFD_ASSERT_NOW(a_result_only_on_accept, res_valid, accept,
        "result produced without an accepted request")

endmodule

`default_nettype wire

// ===== design/wfd_out_stage.sv =====
`default_nettype none

`include "word_frame_deframer_with_sum_assert.svh"

module wfd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wfd_pkg::result_t  push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output wfd_pkg::result_t       out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    wfd_pkg::result_t out_data_reg, out_data_next;
    wfd_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_free;

    // The output slot can load when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // advance the skid entry; no push can arrive while it is full
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `WFD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held while output slot empty")
    `WFD_ASSERT_NOW(a_no_push_when_full, skid_valid_reg, !push,
        "result pushed into a full output stage")
    `WFD_ASSERT_NOW(a_status_is_last, out_valid_reg,
        (out_data_reg.kind == wfd_pkg::KIND_STATUS) == out_data_reg.last,
        "last flag does not match result kind")

endmodule

`default_nettype wire
